>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define HTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("htd assertion failed");

// antecedent implies consequent in the same cycle
`define HTD_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htd implication failed");

`endif

>>> rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// shared types, result codes and datapath operations of the tree decoder
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int NODE_COUNT_DEF   = 512;
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int SYM_W            = 8;
  localparam int CODE_W           = 16;
  localparam int LEN_W            = 5;
  localparam int BYTE_W           = 8;
  localparam int STATUS_W         = 2;

  localparam logic [STATUS_W-1:0] ST_SYMBOL  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_I_STEP,
    S_I_NEW,
    S_I_FETCH,
    S_I_LOAD,
    S_D_FETCH,
    S_D_LOAD,
    S_D_STEP,
    S_D_CHILD,
    S_FLUSH
  } htd_state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD_ITEM,
    DP_I_ADVANCE,
    DP_I_LINK,
    DP_I_NEW,
    DP_I_FETCH,
    DP_I_LOAD,
    DP_I_LABEL,
    DP_I_FULL,
    DP_D_FETCH,
    DP_D_LOAD,
    DP_D_MISS,
    DP_D_READ_KID,
    DP_D_LEAF,
    DP_D_DESCEND,
    DP_FLUSH
  } htd_op_t;

  typedef struct packed {
    logic at_len;
    logic kid_zero;
    logic store_full;
    logic byte_end;
    logic is_leaf;
    logic pend_valid;
    logic out_free;
    logic can_emit;
  } htd_status_t;

endpackage

>>> rtl/htd_node_ram.sv
// ----------------------------------------------------------------------------
// htd_node_ram
// node store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module htd_node_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 26
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/htd_datapath.sv
// ----------------------------------------------------------------------------
// htd_datapath
// item registers, root node, node store access, pending and output request
// ----------------------------------------------------------------------------
module htd_datapath #(
  parameter int NODE_COUNT   = 512,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  htd_pkg::htd_op_t               op,
  output htd_pkg::htd_status_t           sts,
  input  logic                           in_command,
  input  logic [htd_pkg::SYM_W-1:0]      in_symbol,
  input  logic [htd_pkg::CODE_W-1:0]     in_code_bits,
  input  logic [htd_pkg::LEN_W-1:0]      in_code_length,
  input  logic [htd_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [htd_pkg::SYM_W-1:0]      out_symbol_res,
  output logic [htd_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_last
);
  import htd_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = $clog2(NODE_COUNT + 1);
  localparam int J_W   = $clog2(MAX_CODE_LEN + 1);

  typedef struct packed {
    logic [IDX_W-1:0] kid1;
    logic [IDX_W-1:0] kid0;
    logic [SYM_W-1:0] sym;
  } node_ent_t;

  localparam int ENT_W = $bits(node_ent_t);

  node_ent_t          root_r;
  node_ent_t          ent_r;
  node_ent_t          rd_ent;
  node_ent_t          wr_ent;
  logic [CNT_W-1:0]   nodes_used_r;
  logic [IDX_W-1:0]   cur_r;
  logic [IDX_W-1:0]   walk_r;
  logic [IDX_W-1:0]   kid_r;
  logic               mode_r;
  logic [SYM_W-1:0]   sym_r;
  logic [CODE_W-1:0]  code_r;
  logic [J_W-1:0]     len_r;
  logic [J_W-1:0]     j_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [3:0]         i_r;
  logic               pend_valid_r;
  logic [SYM_W-1:0]   pend_sym_r;
  logic [STATUS_W-1:0] pend_st_r;
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_sym_r;
  logic [STATUS_W-1:0] out_st_r;
  logic               out_last_r;

  logic [CODE_W-1:0]  code_sh;
  logic               walk_bit;
  logic [IDX_W-1:0]   kid_sel;
  logic               rd_leaf;
  logic               out_free;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENT_W-1:0]   rd_raw;
  logic               push;
  logic               push_last;
  logic [J_W-1:0]     len_sat;

  assign rd_ent   = node_ent_t'(rd_raw);
  assign code_sh  = code_r >> j_r;
  assign walk_bit = mode_r ? byte_r[i_r[2:0]] : code_sh[0];
  assign kid_sel  = walk_bit ? ent_r.kid1 : ent_r.kid0;
  assign rd_leaf  = (rd_ent.kid0 == '0) && (rd_ent.kid1 == '0);
  assign out_free = !out_valid_r || !out_stall;
  assign len_sat  = (int'(in_code_length) > MAX_CODE_LEN) ? J_W'(MAX_CODE_LEN)
                                                         : J_W'(in_code_length);

  always_comb begin
    sts.at_len     = (j_r == len_r);
    sts.kid_zero   = (kid_sel == '0);
    sts.store_full = (nodes_used_r == CNT_W'(NODE_COUNT));
    sts.byte_end   = i_r[3];
    sts.is_leaf    = rd_leaf;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
    sts.can_emit   = !pend_valid_r || out_free;
  end

  // node store write and read selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = walk_r;
    wr_ent  = ent_r;
    rd_en   = 1'b0;
    rd_addr = walk_r;
    case (op)
      DP_I_LINK: begin
        wr_en = 1'b1;
        if (walk_bit) begin
          wr_ent.kid1 = nodes_used_r[IDX_W-1:0];
        end else begin
          wr_ent.kid0 = nodes_used_r[IDX_W-1:0];
        end
      end
      DP_I_NEW: begin
        wr_en   = 1'b1;
        wr_addr = nodes_used_r[IDX_W-1:0];
        wr_ent  = '0;
      end
      DP_I_LABEL: begin
        wr_en      = 1'b1;
        wr_ent.sym = sym_r;
      end
      DP_I_FETCH: begin
        rd_en = 1'b1;
      end
      DP_D_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = cur_r;
      end
      DP_D_READ_KID: begin
        rd_en   = 1'b1;
        rd_addr = kid_sel;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push      = 1'b0;
    push_last = 1'b0;
    case (op)
      DP_D_MISS, DP_D_LEAF: push = pend_valid_r;
      DP_FLUSH: begin
        push      = 1'b1;
        push_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  htd_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en && (wr_addr != '0)),
    .wr_addr (wr_addr),
    .wr_data (ENT_W'(wr_ent)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r       <= '0;
      nodes_used_r <= CNT_W'(1);
      cur_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (wr_en && (wr_addr == '0)) begin
        root_r <= wr_ent;
      end
      case (op)
        DP_I_NEW: nodes_used_r <= nodes_used_r + CNT_W'(1);
        DP_D_MISS, DP_D_LEAF: cur_r <= '0;
        DP_D_DESCEND: cur_r <= kid_r;
        default: begin
        end
      endcase
      case (op)
        DP_I_LABEL, DP_I_FULL, DP_D_MISS, DP_D_LEAF: pend_valid_r <= 1'b1;
        DP_FLUSH: pend_valid_r <= 1'b0;
        default: begin
        end
      endcase
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_sym_r  <= pend_sym_r;
      out_st_r   <= pend_st_r;
      out_last_r <= push_last;
    end
    case (op)
      DP_LOAD_ITEM: begin
        mode_r <= in_command;
        sym_r  <= in_symbol;
        code_r <= in_code_bits;
        len_r  <= len_sat;
        byte_r <= in_data_byte;
        j_r    <= '0;
        i_r    <= '0;
        walk_r <= '0;
        ent_r  <= root_r;
      end
      DP_I_ADVANCE: begin
        walk_r <= kid_sel;
        j_r    <= j_r + J_W'(1);
      end
      DP_I_NEW: begin
        walk_r <= nodes_used_r[IDX_W-1:0];
        ent_r  <= '0;
        j_r    <= j_r + J_W'(1);
      end
      DP_I_LOAD: ent_r <= rd_ent;
      DP_I_LABEL: begin
        pend_sym_r <= '0;
        pend_st_r  <= ST_DONE;
      end
      DP_I_FULL: begin
        pend_sym_r <= '0;
        pend_st_r  <= ST_FULL;
      end
      DP_D_LOAD: ent_r <= (cur_r == '0) ? root_r : rd_ent;
      DP_D_READ_KID: kid_r <= kid_sel;
      DP_D_MISS: begin
        pend_sym_r <= '0;
        pend_st_r  <= ST_MISSING;
        ent_r      <= root_r;
        i_r        <= i_r + 4'd1;
      end
      DP_D_LEAF: begin
        pend_sym_r <= rd_ent.sym;
        pend_st_r  <= ST_SYMBOL;
        ent_r      <= root_r;
        i_r        <= i_r + 4'd1;
      end
      DP_D_DESCEND: begin
        ent_r <= rd_ent;
        i_r   <= i_r + 4'd1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_symbol_res = out_sym_r;
  assign out_status     = out_st_r;
  assign out_last       = out_last_r;

endmodule

>>> rtl/htd_ctrl.sv
// ----------------------------------------------------------------------------
// htd_ctrl
// sequencer for insert walks, decode walks and the final result flush
// ----------------------------------------------------------------------------
module htd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  input  htd_pkg::htd_status_t sts,
  output htd_pkg::htd_op_t     op,
  output logic                 in_stall
);
  import htd_pkg::*;

  htd_state_t state_r;
  htd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_command == CMD_DECODE) ? S_D_FETCH : S_I_STEP;
        end
      end
      S_I_STEP: begin
        if (sts.at_len) begin
          state_nxt = S_FLUSH;
        end else if (!sts.kid_zero) begin
          state_nxt = S_I_FETCH;
        end else if (sts.store_full) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_I_NEW;
        end
      end
      S_I_NEW:   state_nxt = S_I_STEP;
      S_I_FETCH: state_nxt = S_I_LOAD;
      S_I_LOAD:  state_nxt = S_I_STEP;
      S_D_FETCH: state_nxt = S_D_LOAD;
      S_D_LOAD:  state_nxt = S_D_STEP;
      S_D_STEP: begin
        if (sts.byte_end) begin
          state_nxt = S_FLUSH;
        end else if (!sts.kid_zero) begin
          state_nxt = S_D_CHILD;
        end
      end
      S_D_CHILD: begin
        if (!sts.is_leaf || sts.can_emit) begin
          state_nxt = S_D_STEP;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op = DP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = DP_LOAD_ITEM;
        end
      end
      S_I_STEP: begin
        if (sts.at_len) begin
          op = DP_I_LABEL;
        end else if (!sts.kid_zero) begin
          op = DP_I_ADVANCE;
        end else if (sts.store_full) begin
          op = DP_I_FULL;
        end else begin
          op = DP_I_LINK;
        end
      end
      S_I_NEW:   op = DP_I_NEW;
      S_I_FETCH: op = DP_I_FETCH;
      S_I_LOAD:  op = DP_I_LOAD;
      S_D_FETCH: op = DP_D_FETCH;
      S_D_LOAD:  op = DP_D_LOAD;
      S_D_STEP: begin
        if (sts.byte_end) begin
          op = DP_NONE;
        end else if (!sts.kid_zero) begin
          op = DP_D_READ_KID;
        end else if (sts.can_emit) begin
          op = DP_D_MISS;
        end
      end
      S_D_CHILD: begin
        if (!sts.is_leaf) begin
          op = DP_D_DESCEND;
        end else if (sts.can_emit) begin
          op = DP_D_LEAF;
        end
      end
      S_FLUSH: begin
        if (sts.pend_valid && sts.out_free) begin
          op = DP_FLUSH;
        end
      end
      default: op = DP_NONE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> rtl/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder: node table tree walk, one item at a time
// decode: fetch and load of the current node, then per bit a branch step and one node store read per child
// insert: each existing branch is followed, its node fetched and loaded; each new node is linked and written
// sync reset: root and fill count cleared at once, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_tree_decoder #(
  parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [htd_pkg::SYM_W-1:0]    in_symbol,
  input  logic [htd_pkg::CODE_W-1:0]   in_code_bits,
  input  logic [htd_pkg::LEN_W-1:0]    in_code_length,
  input  logic [htd_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [htd_pkg::SYM_W-1:0]    out_symbol_res,
  output logic [htd_pkg::STATUS_W-1:0] out_status,
  output logic                         out_last
);
  import htd_pkg::*;

  htd_op_t     op;
  htd_status_t sts;

  htd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .sts        (sts),
    .op         (op),
    .in_stall   (in_stall)
  );

  htd_datapath #(
    .NODE_COUNT   (NODE_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .sts            (sts),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol_res (out_symbol_res),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  `HTD_IMPLY(a_flush_has_room, op == DP_FLUSH, sts.pend_valid && sts.out_free)
  `HTD_IMPLY(a_idle_no_pending, !in_stall, !sts.pend_valid)
  `HTD_IMPLY(a_emit_has_room, op == DP_D_MISS || op == DP_D_LEAF, sts.can_emit)
  `HTD_ASSERT(a_push_needs_room, !(op == DP_FLUSH && out_valid && out_stall))

endmodule

>>> tb/sv/tree_walk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tree_walk_checker
// watches both channels of the tree decoder, keeps its own copy of the node
// table, works out the results of every accepted request and compares each
// accepted result field by field with the oldest one still owed
// ----------------------------------------------------------------------------
module tree_walk_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_command,
  input  logic [htd_pkg::SYM_W-1:0]    in_symbol,
  input  logic [htd_pkg::CODE_W-1:0]   in_code_bits,
  input  logic [htd_pkg::LEN_W-1:0]    in_code_length,
  input  logic [htd_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [htd_pkg::SYM_W-1:0]    out_symbol_res,
  input  logic [htd_pkg::STATUS_W-1:0] out_status,
  input  logic                         out_last,
  output int                           owed_count,
  output int                           fault_count
);
  import htd_pkg::*;

  localparam int NODES   = NODE_COUNT_DEF;
  localparam int MAX_LEN = MAX_CODE_LEN_DEF;

  typedef struct packed {
    logic [SYM_W-1:0]    symbol_res;
    logic [STATUS_W-1:0] status;
    logic                last;
  } tree_result_t;

  logic [9:0]       kid [NODES][2];
  logic [SYM_W-1:0] node_sym [NODES];
  int               nodes_used;
  int               walk_node;
  tree_result_t     owed_results[$];

  // from the root, add missing nodes along a code; unless full, label the end
  function automatic logic [STATUS_W-1:0] grow_path(logic [SYM_W-1:0] sym,
                                                    logic [CODE_W-1:0] code,
                                                    logic [LEN_W-1:0] len);
    int steps;
    int node;
    int nxt;
    logic b;
    steps = (len > MAX_LEN) ? MAX_LEN : int'(len);
    node = 0;
    for (int j = 0; j < steps; j++) begin
      b = (j < CODE_W) ? code[j] : 1'b0;
      nxt = kid[node][b];
      if (nxt == 0) begin
        if (nodes_used >= NODES) return ST_FULL;
        nxt = nodes_used;
        nodes_used++;
        kid[nxt][0] = '0;
        kid[nxt][1] = '0;
        node_sym[nxt] = '0;
        kid[node][b] = nxt[9:0];
      end
      node = nxt;
    end
    node_sym[node] = sym;
    return ST_DONE;
  endfunction

  // eight branch steps, lsb first, from wherever the last byte left off
  function automatic void walk_byte(logic [BYTE_W-1:0] data);
    tree_result_t found[$];
    int nxt;
    for (int i = 0; i < BYTE_W; i++) begin
      nxt = kid[walk_node][data[i]];
      if (nxt == 0) begin
        found.insert(found.size(), tree_result_t'{'0, ST_MISSING, 1'b0});
        walk_node = 0;
      end else if (kid[nxt][0] == 0 && kid[nxt][1] == 0) begin
        found.insert(found.size(), tree_result_t'{node_sym[nxt], ST_SYMBOL, 1'b0});
        walk_node = 0;
      end else begin
        walk_node = nxt;
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[k]) owed_results.insert(owed_results.size(), found[k]);
  endfunction

  always @(posedge clk) begin : watch
    tree_result_t want;
    if (!rst_n) begin
      for (int n = 0; n < NODES; n++) begin
        kid[n][0] = '0;
        kid[n][1] = '0;
        node_sym[n] = '0;
      end
      nodes_used = 1;
      walk_node = 0;
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual sym %h status %0d last %b",
                   $time, out_symbol_res, out_status, out_last);
          fault_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_symbol_res !== want.symbol_res) begin
            $display("%0t symbol_res mismatch: expected %h, actual %h",
                     $time, want.symbol_res, out_symbol_res);
            fault_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            fault_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t last mismatch: expected %b, actual %b",
                     $time, want.last, out_last);
            fault_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_command == CMD_INSERT) begin
          owed_results.insert(owed_results.size(),
                              tree_result_t'{'0, grow_path(in_symbol, in_code_bits,
                                                           in_code_length), 1'b1});
        end else begin
          walk_byte(in_data_byte);
        end
      end
    end
    owed_count <= owed_results.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives insert and decode requests into the tree decoder: a short directed
// run over the corner cases, then random tree growth mixed with decodes, and
// finally a store-filling run; results are checked by tree_walk_checker
// ----------------------------------------------------------------------------
module testbench;
  import htd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_command;
  logic [SYM_W-1:0]    in_symbol;
  logic [CODE_W-1:0]   in_code_bits;
  logic [LEN_W-1:0]    in_code_length;
  logic [BYTE_W-1:0]   in_data_byte;
  logic                out_valid;
  logic                out_stall;
  logic [SYM_W-1:0]    out_symbol_res;
  logic [STATUS_W-1:0] out_status;
  logic                out_last;
  logic                calm;
  int                  owed_count;
  int                  fault_count;
  int                  quiet_cycles;

  always #5 clk = ~clk;

  huffman_tree_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol_res (out_symbol_res),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  tree_walk_checker walk_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol_res (out_symbol_res),
    .out_status     (out_status),
    .out_last       (out_last),
    .owed_count     (owed_count),
    .fault_count    (fault_count)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(input logic cmd, input logic [SYM_W-1:0] sym,
                              input logic [CODE_W-1:0] code,
                              input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] data);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_symbol      <= sym;
    in_code_bits   <= code;
    in_code_length <= len;
    in_data_byte   <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic insert_code(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                             input logic [LEN_W-1:0] len);
    push_request(CMD_INSERT, sym, code, len, BYTE_W'($urandom_range(255)));
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] data);
    push_request(CMD_DECODE, SYM_W'($urandom_range(255)), CODE_W'($urandom_range(65535)),
                 LEN_W'($urandom_range(31)), data);
  endtask

  task automatic random_request(input int max_len);
    int pick;
    pick = $urandom_range(99);
    if (pick < 22) begin
      insert_code(SYM_W'($urandom_range(255)), CODE_W'($urandom_range(65535)),
                  LEN_W'($urandom_range(1, max_len)));
    end else if (pick < 26) begin
      insert_code(SYM_W'($urandom_range(255)), CODE_W'($urandom_range(65535)),
                  LEN_W'($urandom_range(7, 16)));
    end else if (pick < 27) begin
      insert_code(SYM_W'($urandom_range(255)), CODE_W'($urandom_range(65535)),
                  LEN_W'($urandom_range(17, 31)));
    end else if (pick < 28) begin
      insert_code(SYM_W'($urandom_range(255)), CODE_W'($urandom_range(65535)), 5'd0);
    end else begin
      decode_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    calm           <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_INSERT;
    in_symbol      <= '0;
    in_code_bits   <= '0;
    in_code_length <= '0;
    in_data_byte   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty tree: every branch missing
    decode_byte(8'h00);
    decode_byte(8'hFF);
    // root label, then a small three-leaf tree
    insert_code(8'hA5, 16'h0000, 5'd0);
    insert_code(8'h00, 16'h0000, 5'd1);
    insert_code(8'hFF, 16'hFFFD, 5'd2);
    insert_code(8'h43, 16'h0003, 5'd2);
    decode_byte(8'h00);
    decode_byte(8'hFF);
    decode_byte(8'h5A);
    // leaves the walk part way down a code
    decode_byte(8'h80);
    insert_code(8'h11, 16'h0000, 5'd2);
    decode_byte(8'h00);
    // longest and overlong codes
    insert_code(8'h7E, 16'hFFFF, 5'd16);
    insert_code(8'h3C, 16'hFFFF, 5'd31);
    insert_code(8'h99, 16'h0000, 5'd17);
    decode_byte(8'hFF);
    decode_byte(8'hFF);
    decode_byte(8'h02);
    decode_byte(8'hAA);
    insert_code(8'h5A, 16'h1234, 5'd16);
    decode_byte(8'h55);

    // random tree growth with mostly short codes, decodes in between
    for (int i = 0; i < 380; i++) begin
      calm <= (i >= 150 && i < 230);
      random_request(6);
    end
    calm <= 1'b0;

    // hold off until the decoder has drained
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);

    // long random codes until the node store runs out, then decode on it
    for (int i = 0; i < 50; i++) begin
      if ($urandom_range(2) == 0) decode_byte(BYTE_W'($urandom_range(255)));
      else insert_code(SYM_W'($urandom_range(255)), CODE_W'($urandom_range(65535)), 5'd16);
    end
    for (int i = 0; i < 30; i++) random_request(16);

    in_valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
